// ----- rtl/psas_pkg.sv -----
// Package with the types and constants of the paged sparse array store.
package psas_pkg;

  localparam int MaxFragments   = 16;
  localparam int MaxFragmentLen = 16;
  localparam int KeyWidth       = 32;
  localparam int FragW          = $clog2(MaxFragments);
  localparam int OffW           = $clog2(MaxFragmentLen);
  localparam int CellW          = FragW + OffW;
  localparam int Cells          = MaxFragments * MaxFragmentLen;
  localparam int RegW           = 5;
  localparam int CountW         = 9;

  typedef enum logic [2:0] {
    ActSet      = 3'd0,
    ActGet      = 3'd1,
    ActDelete   = 3'd2,
    ActContains = 3'd3,
    ActIsSet    = 3'd4,
    ActClear    = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusRange = 2'd1,
    StatusEmpty = 2'd2
  } status_e;

  localparam logic CfgFragCount = 1'b0;
  localparam logic CfgFragLen   = 1'b1;

  typedef struct packed {
    logic [2:0]                 action;
    logic [9:0]                 index;
    logic signed [KeyWidth-1:0] key;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]                 status;
    logic signed [KeyWidth-1:0] value;
    logic                       found;
    logic [CountW-1:0]          element_count;
    logic [RegW-1:0]            active_fragments;
    logic [CountW-1:0]          allocated_cells;
  } out_beat_t;

endpackage

// ----- rtl/paged_sparse_array_store.sv -----
// Paged sparse array store: cell values in a memory, occupancy in flip-flops.
// The input stall stays high while an item is at work or its result beat is
// not taken. Set, get, delete, is-set and clear split the index into fragment
// and offset by repeated subtraction of the fragment length through one
// shared subtractor, then read the value memory (StRead), update (StUpdate)
// and load the result (StDone). An index beyond capacity skips the split and
// goes straight to StDone. Contains-key skips the split and walks the value
// memory one cell per cycle over all configured cells through a registered
// read, and stops early on a hit. Reset needs no clearing pass.
module paged_sparse_array_store (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  psas_pkg::in_beat_t   in_data_i,
  output logic                 out_valid,
  input  logic                 out_stall,
  output psas_pkg::out_beat_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [4:0]           cfg_data_i
);

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StDiv    = 6'b000010,
    StRead   = 6'b000100,
    StUpdate = 6'b001000,
    StScan   = 6'b010000,
    StDone   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [psas_pkg::RegW-1:0] frag_count_q, frag_len_q;
  logic [psas_pkg::MaxFragments-1:0][psas_pkg::MaxFragmentLen-1:0] occ_q;
  logic [psas_pkg::MaxFragments-1:0][psas_pkg::OffW:0] frag_occ_q;
  logic [psas_pkg::MaxFragments-1:0] active_q;
  logic [psas_pkg::CountW-1:0] total_q;
  logic [psas_pkg::RegW-1:0]   act_cnt_q;

  logic signed [psas_pkg::KeyWidth-1:0] mem_q [psas_pkg::Cells];
  logic signed [psas_pkg::KeyWidth-1:0] rd_q;

  psas_pkg::in_beat_t item_q;
  logic [9:0] rem_q;
  logic [psas_pkg::FragW:0] frag_q;
  logic [psas_pkg::OffW:0]  off_q;
  logic                     in_range_q;
  logic                     found_q;
  logic                     cmp_q;
  logic                     out_valid_q;
  psas_pkg::out_beat_t      out_q;
  logic [psas_pkg::FragW-1:0] f_idx;
  logic [psas_pkg::OffW-1:0]  o_idx;
  logic [psas_pkg::CellW-1:0] addr;
  logic [9:0] diff;
  logic       cell_set;
  logic       scan_live;
  logic [psas_pkg::RegW-1:0] cfg_val;

  assign f_idx     = frag_q[psas_pkg::FragW-1:0];
  assign o_idx     = off_q[psas_pkg::OffW-1:0];
  assign addr      = {f_idx, o_idx};
  assign diff      = rem_q - 10'(frag_len_q);
  assign cell_set  = active_q[f_idx] && occ_q[f_idx][o_idx];
  assign scan_live = frag_q < (psas_pkg::FragW+1)'(frag_count_q);
  assign cfg_val   = (cfg_data_i == '0) ? psas_pkg::RegW'(1) :
                     (cfg_data_i > psas_pkg::RegW'(psas_pkg::MaxFragments)) ?
                     psas_pkg::RegW'(psas_pkg::MaxFragments) : cfg_data_i;

  assign in_stall   = (state_q != StIdle) || out_valid_q;
  assign out_valid  = out_valid_q;
  assign out_data_o = out_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_valid && !in_stall) state_d = StDiv;
      StDiv: begin
        if (!in_range_q) begin
          state_d = StDone;
        end else if (item_q.action == psas_pkg::ActContains) begin
          state_d = StScan;
        end else if (rem_q >= 10'(frag_len_q)) begin
          state_d = StDiv;
        end else begin
          state_d = StRead;
        end
      end
      StRead:   state_d = StUpdate;
      StUpdate: state_d = StDone;
      StScan: begin
        if (found_q || (!scan_live && !cmp_q)) state_d = StDone;
      end
      StDone:   state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid && !in_stall) item_q <= in_data_i;
    if (state_q == StUpdate && item_q.action == psas_pkg::ActSet) begin
      mem_q[addr] <= item_q.key;
    end
    rd_q <= mem_q[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      frag_count_q <= psas_pkg::RegW'(psas_pkg::MaxFragments);
      frag_len_q   <= psas_pkg::RegW'(psas_pkg::MaxFragmentLen);
      occ_q        <= '0;
      frag_occ_q   <= '0;
      active_q     <= '0;
      total_q      <= '0;
      act_cnt_q    <= '0;
      rem_q        <= '0;
      frag_q       <= '0;
      off_q        <= '0;
      in_range_q   <= 1'b0;
      found_q      <= 1'b0;
      cmp_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_index_i == psas_pkg::CfgFragCount) frag_count_q <= cfg_val;
        else frag_len_q <= cfg_val;
        occ_q     <= '0;
        frag_occ_q <= '0;
        active_q  <= '0;
        total_q   <= '0;
        act_cnt_q <= '0;
      end
      case (state_q)
        StIdle: begin
          rem_q   <= in_data_i.index;
          frag_q  <= '0;
          found_q <= 1'b0;
          in_range_q <= (in_data_i.action == psas_pkg::ActContains) ||
                        ({1'b0, in_data_i.index} <
                         11'(frag_count_q) * 11'(frag_len_q));
        end
        StDiv: begin
          cmp_q <= 1'b0;
          if (item_q.action == psas_pkg::ActContains) begin
            frag_q <= '0;
            off_q  <= '0;
          end else if (rem_q >= 10'(frag_len_q)) begin
            rem_q  <= diff;
            frag_q <= frag_q + 1'b1;
          end else begin
            off_q <= rem_q[psas_pkg::OffW:0];
          end
        end
        StScan: begin
          if (cmp_q && rd_q == item_q.key) found_q <= 1'b1;
          cmp_q <= scan_live && cell_set;
          if (scan_live) begin
            if (off_q + 1'b1 >= (psas_pkg::OffW+1)'(frag_len_q)) begin
              off_q  <= '0;
              frag_q <= frag_q + 1'b1;
            end else begin
              off_q <= off_q + 1'b1;
            end
          end
        end
        StUpdate: begin
          case (item_q.action)
            psas_pkg::ActSet: begin
              if (!active_q[f_idx]) begin
                active_q[f_idx] <= 1'b1;
                act_cnt_q <= act_cnt_q + 1'b1;
              end
              if (!cell_set) begin
                occ_q[f_idx] <= (active_q[f_idx] ? occ_q[f_idx] : '0) |
                                (psas_pkg::MaxFragmentLen'(1) << o_idx);
                frag_occ_q[f_idx] <= (active_q[f_idx] ? frag_occ_q[f_idx] : '0) + 1'b1;
                total_q <= total_q + 1'b1;
              end
            end
            psas_pkg::ActDelete: begin
              if (cell_set) begin
                occ_q[f_idx][o_idx] <= 1'b0;
                frag_occ_q[f_idx] <= frag_occ_q[f_idx] - 1'b1;
                total_q <= total_q - 1'b1;
                if (frag_occ_q[f_idx] == (psas_pkg::OffW+1)'(1)) begin
                  active_q[f_idx] <= 1'b0;
                  act_cnt_q <= act_cnt_q - 1'b1;
                end
              end
            end
            psas_pkg::ActClear: begin
              occ_q     <= '0;
              frag_occ_q <= '0;
              active_q  <= '0;
              total_q   <= '0;
              act_cnt_q <= '0;
            end
            default: ;
          endcase
          out_q.status <= psas_pkg::StatusOk;
          out_q.value  <= '0;
          out_q.found  <= 1'b0;
          case (item_q.action)
            psas_pkg::ActGet: begin
              if (cell_set) out_q.value <= rd_q;
              else out_q.status <= psas_pkg::StatusEmpty;
            end
            psas_pkg::ActDelete: if (!cell_set) out_q.status <= psas_pkg::StatusEmpty;
            psas_pkg::ActIsSet: begin
              if (cell_set) out_q.found <= 1'b1;
              else out_q.status <= psas_pkg::StatusEmpty;
            end
            default: ;
          endcase
        end
        StDone: begin
          out_valid_q <= 1'b1;
          out_q.element_count    <= total_q;
          out_q.active_fragments <= act_cnt_q;
          out_q.allocated_cells  <= psas_pkg::CountW'(act_cnt_q) *
                                    psas_pkg::CountW'(frag_len_q);
          if (item_q.action == psas_pkg::ActContains) begin
            out_q.status <= psas_pkg::StatusOk;
            out_q.value  <= '0;
            out_q.found  <= found_q;
          end else if (!in_range_q) begin
            out_q.status <= psas_pkg::StatusRange;
            out_q.value  <= '0;
            out_q.found  <= 1'b0;
            if (item_q.action == psas_pkg::ActClear) begin
              out_q.status <= psas_pkg::StatusOk;
            end
          end
          if (item_q.action == psas_pkg::ActClear ||
              item_q.action > psas_pkg::ActClear) begin
            out_q.status <= psas_pkg::StatusOk;
            out_q.value  <= '0;
            out_q.found  <= 1'b0;
            if (item_q.action == psas_pkg::ActClear) begin
              out_q.element_count    <= '0;
              out_q.active_fragments <= '0;
              out_q.allocated_cells  <= '0;
              occ_q     <= '0;
              frag_occ_q <= '0;
              active_q  <= '0;
              total_q   <= '0;
              act_cnt_q <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/psas_checker.sv -----
// Port checker for the paged sparse array store, bound to the top level.
module psas_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input psas_pkg::out_beat_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(out_data_o))
    else $error("result beat changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is at work");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> in_stall)
    else $error("input open while a result waits");

  a_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data_o.allocated_cells >= 9'(out_data_o.active_fragments))
    else $error("allocated cells below active fragments");

endmodule

bind paged_sparse_array_store psas_checker u_psas_checker (.*);
